// File: src/ptt_pkg.sv
// package for the periodic timer table: sizes, codes and item types
`timescale 1ns / 1ps
`default_nettype none
package ptt_pkg;

  // table size and derived widths
  localparam int NumTimers = 16;
  localparam int IdxW      = (NumTimers > 1) ? $clog2(NumTimers) : 1;
  localparam int CntW      = $clog2(NumTimers + 1);

  // command codes
  localparam logic [1:0] CmdAdd   = 2'd0;
  localparam logic [1:0] CmdDel   = 2'd1;
  localparam logic [1:0] CmdClear = 2'd2;
  localparam logic [1:0] CmdTick  = 2'd3;

  // result kinds
  localparam logic [2:0] KindDone     = 3'd0;
  localparam logic [2:0] KindRejected = 3'd1;
  localparam logic [2:0] KindNotFound = 3'd2;
  localparam logic [2:0] KindFired    = 3'd3;
  localparam logic [2:0] KindNoneDue  = 3'd4;

  // input item
  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] timer_id;
    logic [31:0] interval_ms;
    logic [31:0] now_ms;
  } ptt_in_t;

  // result item
  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] fired_id;
    logic        last;
  } ptt_out_t;

  // one table entry
  typedef struct packed {
    logic [15:0] id;
    logic [31:0] period;
    logic [31:0] last_fire;
  } ptt_entry_t;

  // write port of the entry store
  typedef struct packed {
    logic             en;
    logic [IdxW-1:0]  addr;
    ptt_entry_t       data;
  } ptt_wr_t;

endpackage
`default_nettype wire

// File: src/ptt_store.sv
// entry store of the timer table: one write port, one read port
`timescale 1ns / 1ps
`default_nettype none
module ptt_store import ptt_pkg::*; (
  input  wire logic            clk_i,
  input  wire ptt_wr_t         wr_i,
  input  wire logic [IdxW-1:0] rd_addr_i,
  output ptt_entry_t           rd_data_o
);

  ptt_entry_t entries_q [NumTimers];

  // write one entry
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      entries_q[wr_i.addr] <= wr_i.data;
    end
  end

  // read one entry
  assign rd_data_o = entries_q[rd_addr_i];

endmodule
`default_nettype wire

// File: src/periodic_timer_table_top.sv
// periodic timer table: command sequencer, shared due-time compare and result register
// add and clear register their result from the exec state; delete searches and shifts;
// a tick visits one entry per cycle by the single subtract-and-compare unit, unless a
// held fired id is stalled; the next item is taken the cycle after the last result
// results leave through an output register, so back pressure only holds the sequencer
// reset empties the table and the output register; entry contents are not cleared
`timescale 1ns / 1ps
`default_nettype none
module periodic_timer_table_top import ptt_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire ptt_in_t  in_data_i,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output ptt_out_t      out_data_o
);

  // sequencer states
  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StExec   = 3'd1;
  localparam logic [2:0] StSearch = 3'd2;
  localparam logic [2:0] StShift  = 3'd3;
  localparam logic [2:0] StScan   = 3'd4;

  logic [2:0]      state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] idx_q, idx_d;
  logic [CntW-1:0] idx_nxt;
  logic            pend_v_q, pend_v_d;
  logic [15:0]     pend_id_q, pend_id_d;
  ptt_in_t         cur_q, cur_d;
  logic            out_valid_q, out_valid_d;
  ptt_out_t        out_q, out_d;

  logic            accept;
  logic            out_free;
  logic            emit;
  ptt_out_t        emit_data;
  ptt_wr_t         wr;
  logic [IdxW-1:0] rd_addr;
  ptt_entry_t      rd_entry;
  logic [31:0]     elapsed;
  logic            due;

  ptt_store u_store (
    .clk_i     (clk_i),
    .wr_i      (wr),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_entry)
  );

  assign accept   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign idx_nxt  = idx_q + 1'b1;

  // shift reads the entry after the current one
  assign rd_addr = (state_q == StShift) ? idx_nxt[IdxW-1:0] : idx_q[IdxW-1:0];

  // shared due-time unit: wrapping elapsed time against period
  assign elapsed = cur_q.now_ms - rd_entry.last_fire;
  assign due     = (elapsed >= rd_entry.period);

  // sequencer
  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    idx_d     = idx_q;
    pend_v_d  = pend_v_q;
    pend_id_d = pend_id_q;
    cur_d     = cur_q;
    emit      = 1'b0;
    emit_data = '{kind: KindDone, fired_id: cur_q.timer_id, last: 1'b1};
    wr        = '0;
    case (state_q)
      StIdle: begin
        if (accept) begin
          cur_d   = in_data_i;
          state_d = StExec;
        end
      end
      StExec: begin
        case (cur_q.cmd)
          CmdAdd: begin
            if (out_free) begin
              emit    = 1'b1;
              state_d = StIdle;
              if (cur_q.interval_ms == 32'd0 || count_q == CntW'(NumTimers)) begin
                emit_data.kind = KindRejected;
              end else begin
                wr.en   = 1'b1;
                wr.addr = count_q[IdxW-1:0];
                wr.data = '{id: cur_q.timer_id, period: cur_q.interval_ms,
                            last_fire: cur_q.now_ms};
                count_d = count_q + 1'b1;
              end
            end
          end
          CmdDel: begin
            idx_d   = '0;
            state_d = StSearch;
          end
          CmdClear: begin
            if (out_free) begin
              emit    = 1'b1;
              count_d = '0;
              state_d = StIdle;
            end
          end
          default: begin
            idx_d    = '0;
            pend_v_d = 1'b0;
            state_d  = StScan;
          end
        endcase
      end
      StSearch: begin
        if (idx_q == count_q) begin
          if (out_free) begin
            emit           = 1'b1;
            emit_data.kind = KindNotFound;
            state_d        = StIdle;
          end
        end else if (rd_entry.id == cur_q.timer_id) begin
          state_d = StShift;
        end else begin
          idx_d = idx_nxt;
        end
      end
      StShift: begin
        // move later entries up one place, then drop the tail
        if (idx_nxt < count_q) begin
          wr.en   = 1'b1;
          wr.addr = idx_q[IdxW-1:0];
          wr.data = rd_entry;
          idx_d   = idx_nxt;
        end else if (out_free) begin
          count_d = count_q - 1'b1;
          emit    = 1'b1;
          state_d = StIdle;
        end
      end
      StScan: begin
        // one fired id is held back so the final one can carry last
        if (idx_q == count_q) begin
          if (out_free) begin
            emit    = 1'b1;
            state_d = StIdle;
            if (pend_v_q) begin
              emit_data = '{kind: KindFired, fired_id: pend_id_q, last: 1'b1};
            end else begin
              emit_data = '{kind: KindNoneDue, fired_id: 16'd0, last: 1'b1};
            end
          end
        end else if (due) begin
          if (!pend_v_q || out_free) begin
            if (pend_v_q) begin
              emit      = 1'b1;
              emit_data = '{kind: KindFired, fired_id: pend_id_q, last: 1'b0};
            end
            wr.en     = 1'b1;
            wr.addr   = idx_q[IdxW-1:0];
            wr.data   = '{id: rd_entry.id, period: rd_entry.period,
                          last_fire: cur_q.now_ms};
            pend_v_d  = 1'b1;
            pend_id_d = rd_entry.id;
            idx_d     = idx_nxt;
          end
        end else begin
          idx_d = idx_nxt;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (emit) begin
      out_valid_d = 1'b1;
      out_d       = emit_data;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      idx_q       <= '0;
      pend_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      pend_v_q    <= pend_v_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cur_q     <= cur_d;
    pend_id_q <= pend_id_d;
    out_q     <= out_d;
  end

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

// File: test/tb_periodic_timer_table_top.sv
// testbench for the periodic timer table: directed rows, random commands, shadow table check
`timescale 1ns / 1ps
module tb_periodic_timer_table_top;
  import ptt_pkg::*;

  // slowest run: ~160 items, up to 16 results each, heavy receiver stall, plus a long receiver hold
  localparam int CycleLimit  = 400000;
  localparam int HoldCycles  = 400;
  localparam int SettleCycles = 50;

  // receiver stall patterns
  typedef enum logic [1:0] {RxFree, RxPatchy, RxBusy} rx_mode_e;

  // one directed row; result is only meaningful when typed is set
  typedef struct packed {
    ptt_in_t  item;
    logic     typed;
    ptt_out_t result;
  } dir_row_t;

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_stall_o;
  ptt_in_t  in_data_i;
  logic     out_valid_o;
  logic     out_stall_i;
  ptt_out_t out_data_o;

  periodic_timer_table_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // shadow copy of the timer list
  ptt_entry_t shadow_slots [NumTimers];
  int         shadow_count;
  logic [31:0] clock_ms;

  ptt_out_t   tick_results [$];
  ptt_out_t   pending_timer_results [$];
  dir_row_t   dir_rows [$];

  int mismatches;
  int items_sent;
  int results_checked;
  int fired_seen;
  int rejected_seen;
  int notfound_seen;
  int burst_left;
  int cycle_count;
  bit hold_off_req;

  // clock
  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  function automatic ptt_out_t mk_result(input logic [2:0] kind, input logic [15:0] id,
                                         input logic last);
    ptt_out_t r;
    r.kind     = kind;
    r.fired_id = id;
    r.last     = last;
    return r;
  endfunction

  // append one result to the list for the current command
  function automatic void add_tick_result(input ptt_out_t r);
    tick_results.insert(tick_results.size(), r);
  endfunction

  // apply one command to the shadow table and collect the results it causes
  function automatic void predict_timer_results(input ptt_in_t item);
    int hit;
    logic [31:0] elapsed;
    tick_results.delete();
    case (item.cmd)
      CmdAdd: begin
        if (item.interval_ms == 32'd0 || shadow_count >= NumTimers) begin
          add_tick_result(mk_result(KindRejected, item.timer_id, 1'b1));
        end else begin
          shadow_slots[shadow_count].id        = item.timer_id;
          shadow_slots[shadow_count].period    = item.interval_ms;
          shadow_slots[shadow_count].last_fire = item.now_ms;
          shadow_count++;
          add_tick_result(mk_result(KindDone, item.timer_id, 1'b1));
        end
      end
      CmdDel: begin
        hit = -1;
        for (int i = 0; i < shadow_count; i++) begin
          if (hit < 0 && shadow_slots[i].id == item.timer_id) hit = i;
        end
        if (hit < 0) begin
          add_tick_result(mk_result(KindNotFound, item.timer_id, 1'b1));
        end else begin
          // later entries move up one place
          for (int i = hit; i + 1 < shadow_count; i++) shadow_slots[i] = shadow_slots[i + 1];
          shadow_count--;
          add_tick_result(mk_result(KindDone, item.timer_id, 1'b1));
        end
      end
      CmdClear: begin
        shadow_count = 0;
        add_tick_result(mk_result(KindDone, item.timer_id, 1'b1));
      end
      default: begin
        // tick: visit entries in list order, wrapping elapsed time
        for (int i = 0; i < shadow_count; i++) begin
          elapsed = item.now_ms - shadow_slots[i].last_fire;
          if (elapsed >= shadow_slots[i].period) begin
            shadow_slots[i].last_fire = item.now_ms;
            add_tick_result(mk_result(KindFired, shadow_slots[i].id, 1'b0));
          end
        end
        if (tick_results.size() == 0) begin
          add_tick_result(mk_result(KindNoneDue, 16'd0, 1'b1));
        end else begin
          tick_results[tick_results.size() - 1].last = 1'b1;
        end
      end
    endcase
  endfunction

  // random command, mostly well formed against the shadow table
  function automatic ptt_in_t random_command();
    ptt_in_t c;
    int sel;
    int pick;
    int add_share;
    sel = $urandom_range(0, 99);
    add_share = (shadow_count < 12) ? 40 : 20;
    c.timer_id    = 16'($urandom_range(0, 65535));
    c.interval_ms = $urandom;
    c.now_ms      = clock_ms;
    if (sel < 3) begin
      c.cmd = CmdClear;
    end else if (sel < 6) begin
      // noise: every field random
      c.cmd    = 2'($urandom_range(0, 3));
      c.now_ms = $urandom;
    end else if (sel < 6 + add_share) begin
      c.cmd = CmdAdd;
      if ($urandom_range(0, 9) < 7) c.timer_id = 16'($urandom_range(0, 7));
      pick = $urandom_range(0, 19);
      if (pick < 16) c.interval_ms = $urandom_range(1, 40);
      else if (pick == 16) c.interval_ms = 32'd0;
      else if (pick == 17) c.interval_ms = 32'hFFFF_FFFF;
    end else if (sel < 21 + add_share) begin
      c.cmd = CmdDel;
      if (shadow_count > 0 && $urandom_range(0, 3) != 0)
        c.timer_id = shadow_slots[$urandom_range(0, shadow_count - 1)].id;
      else if ($urandom_range(0, 1) == 1)
        c.timer_id = 16'($urandom_range(0, 7));
    end else begin
      c.cmd = CmdTick;
      if ($urandom_range(0, 19) == 0) clock_ms = $urandom;
      else clock_ms = clock_ms + 32'($urandom_range(0, 25));
      c.now_ms = clock_ms;
    end
    return c;
  endfunction

  task automatic add_row(input logic [1:0] cmd, input logic [15:0] id, input logic [31:0] ivl,
                         input logic [31:0] now, input logic typed, input logic [2:0] kind);
    dir_row_t row;
    row.item.cmd         = cmd;
    row.item.timer_id    = id;
    row.item.interval_ms = ivl;
    row.item.now_ms      = now;
    row.typed            = typed;
    row.result           = mk_result(kind, (kind == KindNoneDue) ? 16'd0 : id, 1'b1);
    dir_rows.insert(dir_rows.size(), row);
  endtask

  // directed table: reset state, extremes, duplicates, wrap, full table, mid-list delete
  task automatic load_directed_rows();
    add_row(CmdTick,  16'h0000, 32'h0,         32'h0,         1'b1, KindNoneDue);
    add_row(CmdDel,   16'h0005, 32'h0,         32'h0,         1'b1, KindNotFound);
    add_row(CmdClear, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, KindDone);
    add_row(CmdAdd,   16'h0000, 32'h0,         32'h0,         1'b1, KindRejected);
    add_row(CmdAdd,   16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, KindDone);
    add_row(CmdAdd,   16'h0001, 32'd1,         32'h0,         1'b1, KindDone);
    add_row(CmdAdd,   16'h0001, 32'd10,        32'h0,         1'b1, KindDone);
    add_row(CmdTick,  16'h0000, 32'h0,         32'd1,         1'b0, KindDone);
    add_row(CmdDel,   16'h0001, 32'h0,         32'h0,         1'b1, KindDone);
    add_row(CmdTick,  16'h0000, 32'h0,         32'hFFFF_FFFE, 1'b0, KindDone);
    // fill the table to the top
    for (int k = 0; k < NumTimers - 2; k++)
      add_row(CmdAdd, 16'(16'h0100 + k), 32'(k + 1), 32'hFFFF_FFF0, 1'b1, KindDone);
    add_row(CmdAdd,   16'h8000, 32'd5,         32'h0,         1'b1, KindRejected);
    add_row(CmdTick,  16'h0000, 32'h0,         32'h0000_1000, 1'b0, KindDone);
    add_row(CmdDel,   16'h010D, 32'h0,         32'h0,         1'b1, KindDone);
    add_row(CmdClear, 16'h1234, 32'h0,         32'h0,         1'b1, KindDone);
  endtask

  // drive one item at the falling edge and hold it until accepted
  task automatic send_command(input ptt_in_t item, input logic typed, input ptt_out_t typed_res);
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (in_stall_o);
    predict_timer_results(item);
    if (typed) pending_timer_results.insert(pending_timer_results.size(), typed_res);
    else foreach (tick_results[i])
      pending_timer_results.insert(pending_timer_results.size(), tick_results[i]);
    items_sent++;
  endtask

  task automatic idle_sender(input int n);
    for (int k = 0; k < n; k++) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
  endtask

  // bursts of random length with random gaps, unless steady
  task automatic pace_sender(input bit steady);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if (!steady) idle_sender($urandom_range(1, 8));
    end
    burst_left--;
  endtask

  task automatic run_random(input int count);
    ptt_in_t c;
    for (int i = 0; i < count; i++) begin
      pace_sender((i % 60) >= 45);
      c = random_command();
      send_command(c, 1'b0, '0);
    end
  endtask

  task automatic wait_drained();
    while (pending_timer_results.size() != 0) @(posedge clk_i);
  endtask

  // receiver: stall pattern of its own, plus one long hold-off on request
  initial begin
    rx_mode_e mode;
    int mode_left;
    int hold_left;
    mode = RxFree;
    mode_left = 0;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_off_req) begin
        hold_left = HoldCycles;
        while (hold_left > 0) begin
          @(negedge clk_i);
          out_stall_i <= 1'b1;
          hold_left--;
        end
        hold_off_req = 1'b0;
      end else begin
        @(negedge clk_i);
        if (mode_left == 0) begin
          mode = rx_mode_e'($urandom_range(0, 2));
          mode_left = $urandom_range(16, 80);
        end
        mode_left--;
        case (mode)
          RxFree:   out_stall_i <= 1'b0;
          RxPatchy: out_stall_i <= 1'($urandom_range(0, 1));
          default:  out_stall_i <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  // result checker
  always @(posedge clk_i) begin
    ptt_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_timer_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind %0d id %h last %b",
                                  out_data_o.kind, out_data_o.fired_id, out_data_o.last));
      end else begin
        want = pending_timer_results.pop_front();
        results_checked++;
        if (out_data_o.kind != want.kind)
          report_mismatch($sformatf("kind %0d, expected %0d", out_data_o.kind, want.kind));
        if (out_data_o.fired_id != want.fired_id)
          report_mismatch($sformatf("id %h, expected %h", out_data_o.fired_id, want.fired_id));
        if (out_data_o.last != want.last)
          report_mismatch($sformatf("last %b, expected %b", out_data_o.last, want.last));
        case (want.kind)
          KindFired:    fired_seen++;
          KindRejected: rejected_seen++;
          KindNotFound: notfound_seen++;
          default: ;
        endcase
      end
    end
  end

  // watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results still pending", cycle_count,
             pending_timer_results.size());
    $display("tb_periodic_timer_table_top NOT OK");
    $finish;
  end

  // stimulus
  initial begin
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    in_data_i    = '0;
    hold_off_req = 1'b0;
    shadow_count = 0;
    burst_left   = 0;
    mismatches   = 0;
    items_sent   = 0;
    results_checked = 0;
    fired_seen   = 0;
    rejected_seen = 0;
    notfound_seen = 0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed rows
    load_directed_rows();
    foreach (dir_rows[i]) begin
      pace_sender(1'b0);
      send_command(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].result);
    end

    // random commands, clock starting just short of the wrap
    clock_ms = 32'hFFFF_FF80;
    run_random(80);

    // sender pause until every result is back
    idle_sender(1);
    wait_drained();

    // long receiver hold while the sender keeps offering
    hold_off_req = 1'b1;
    for (int i = 0; i < 30; i++) send_command(random_command(), 1'b0, '0);
    run_random(22);

    idle_sender(1);
    wait_drained();
    repeat (SettleCycles) @(posedge clk_i);

    $display("covered %0d commands, %0d results: %0d firings, %0d rejects, %0d misses",
             items_sent, results_checked, fired_seen, rejected_seen, notfound_seen);
    $display("included a %0d cycle output hold and a full drain pause; %0d mismatches",
             HoldCycles, mismatches);
    if (mismatches == 0) begin
      $display("tb_periodic_timer_table_top OK");
    end else begin
      $display("tb_periodic_timer_table_top NOT OK");
    end
    $finish;
  end

endmodule
